### src/scint_pkg.sv
// Package for the score calibration interpolator: field widths, codes,
// command, result and table entry types.
// No dependencies.
`default_nettype none

package scint_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int PROB_FRAC_BITS  = 24;
  localparam int PROB_W          = PROB_FRAC_BITS + 1;
  localparam int SCORE_W         = 32;
  localparam int IDX_W           = 6;
  localparam int CNT_W           = 7;

  localparam logic [PROB_W-1:0] PROB_ONE  = PROB_W'(1) << PROB_FRAC_BITS;
  localparam logic [PROB_W-1:0] PROB_TINY = PROB_W'(2);
  localparam logic [PROB_W-1:0] PROB_MASK = {PROB_W{1'b1}};

  localparam logic [1:0] OP_WRITE       = 2'd0;
  localparam logic [1:0] OP_QUERY_SCORE = 2'd1;
  localparam logic [1:0] OP_QUERY_INDEX = 2'd2;
  localparam logic [1:0] OP_NONE        = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0]                operation;
    logic [IDX_W-1:0]          entry_index;
    logic signed [SCORE_W-1:0] threshold_value;
    logic [PROB_W-1:0]         entry_probability;
    logic signed [SCORE_W-1:0] score;
  } cmd_t;

  typedef struct packed {
    logic [PROB_W-1:0] probability;
    logic [IDX_W-1:0]  bucket;
    logic [1:0]        status;
  } res_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] thr;
    logic [PROB_W-1:0]         prob;
  } entry_t;

endpackage

`default_nettype wire

### src/scint_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
`default_nettype none

module scint_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

### src/scint_div.sv
// Restoring divider, one quotient bit per cycle, for a quotient known to fit
// in QUOT_W bits. Depends on nothing outside this file.
`default_nettype none

module scint_div #(
  parameter int DIVISOR_W  = 32,
  parameter int QUOT_W     = 25,
  parameter int DIVIDEND_W = DIVISOR_W + QUOT_W
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  start,
  input  wire logic [DIVIDEND_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]  divisor,
  output logic                       done,
  output logic      [QUOT_W-1:0]     quotient
);

  localparam int CW = $clog2(QUOT_W + 1);

  logic [DIVISOR_W-1:0] rem;
  logic [QUOT_W-1:0]    quo;
  logic [CW-1:0]        cnt;
  logic                 running;
  logic [DIVISOR_W:0]   trial;
  logic [DIVISOR_W:0]   diff;
  logic                 ge;

  always_comb begin
    trial = {rem, quo[QUOT_W-1]};
    ge    = trial >= {1'b0, divisor};
    diff  = trial - {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        // upper part is below the divisor, as the quotient fits QUOT_W bits
        rem     <= dividend[DIVIDEND_W-1 -: DIVISOR_W];
        quo     <= dividend[QUOT_W-1:0];
        cnt     <= CW'(QUOT_W);
        running <= 1'b1;
      end else if (running) begin
        rem <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        quo <= {quo[QUOT_W-2:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

`default_nettype wire

### src/score_calibration_interpolator.sv
// Score calibration interpolator: bucket table in RAM, serial threshold scan
// and a bit-serial divider for interpolation between buckets.
// Write, empty or out-of-range query and unknown operation finish in decode;
// an index query adds a RAM read; a score query scans k entries, a RAM read
// and a compare each, then if it interpolates one multiply and 25 divider
// steps. Busy until the result strobe: no new command is taken before then.
// Synchronous reset clears the sequencer and entries_in_use; table contents
// are undefined until written. The result is strobed once and cannot stall.
// Depends on scint_pkg, scint_ram and scint_div.
`default_nettype none

module score_calibration_interpolator #(
  parameter int TABLE_DEPTH = scint_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire scint_pkg::cmd_t               cmd,
  output logic                               done,
  output scint_pkg::res_t                    result,
  input  wire logic                          cfg_we,
  input  wire logic [scint_pkg::CNT_W-1:0]   cfg_wdata
);

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int PW  = scint_pkg::PROB_W;
  localparam int SW  = scint_pkg::SCORE_W;
  localparam int NW  = scint_pkg::CNT_W;
  localparam int EW  = $bits(scint_pkg::entry_t);
  localparam int IDX_W_SEL = scint_pkg::IDX_W;

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DECODE   = 4'd1;
  localparam logic [3:0] S_IDXRD    = 4'd2;
  localparam logic [3:0] S_SCAN_RD  = 4'd3;
  localparam logic [3:0] S_SCAN_CMP = 4'd4;
  localparam logic [3:0] S_MUL      = 4'd5;
  localparam logic [3:0] S_DIV_GO   = 4'd6;
  localparam logic [3:0] S_DIV      = 4'd7;

  logic [3:0]          state;
  logic [NW-1:0]       entries_in_use;
  logic [NW-1:0]       n_active;
  scint_pkg::cmd_t     cmd_reg;
  logic [NW-1:0]       scan_i;
  logic signed [SW-1:0] cur_thr;
  logic signed [SW-1:0] prev_thr;
  logic [PW-1:0]       cur_prob;
  logic [PW-1:0]       prev_prob;
  logic [SW+PW-1:0]    product;
  logic [SW-1:0]       span;
  logic                neg;

  logic                ram_we;
  logic [AW-1:0]       ram_addr;
  scint_pkg::entry_t   ram_wentry;
  logic [EW-1:0]       ram_rdata;
  scint_pkg::entry_t   rd;

  logic                div_start;
  logic                div_done;
  logic [PW-1:0]       quot;

  logic [PW-1:0]       wr_prob;
  logic [SW:0]         dist_full;
  logic [SW:0]         span_full;
  logic signed [PW:0]  prob_diff;
  logic [PW-1:0]       prob_mag;
  logic signed [PW+1:0] interp;
  logic [PW-1:0]       interp_clamped;
  logic [PW-1:0]       last_floored;
  logic                idx_in_table;

  // entries_in_use saturated to the table depth
  always_comb begin
    if (int'(entries_in_use) > TABLE_DEPTH) begin
      n_active = NW'(TABLE_DEPTH);
    end else begin
      n_active = entries_in_use;
    end
  end

  always_comb begin
    wr_prob = cmd_reg.entry_probability;
    if (wr_prob > scint_pkg::PROB_ONE) begin
      wr_prob = scint_pkg::PROB_ONE;
    end
    if (wr_prob < scint_pkg::PROB_TINY) begin
      wr_prob = scint_pkg::PROB_TINY;
    end
  end

  assign idx_in_table = int'(cmd_reg.entry_index) < TABLE_DEPTH;
  assign rd           = scint_pkg::entry_t'(ram_rdata);

  always_comb begin
    ram_wentry.thr  = cmd_reg.threshold_value;
    ram_wentry.prob = wr_prob;
    ram_we   = (state == S_DECODE) && (cmd_reg.operation == scint_pkg::OP_WRITE) &&
               idx_in_table;
    ram_addr = (state == S_SCAN_RD) ? AW'(scan_i) : AW'(cmd_reg.entry_index);
  end

  scint_ram #(
    .WIDTH(EW),
    .DEPTH(TABLE_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wentry),
    .rdata(ram_rdata)
  );

  assign div_start = (state == S_DIV_GO);

  scint_div #(
    .DIVISOR_W(SW),
    .QUOT_W   (PW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(product),
    .divisor (span),
    .done    (div_done),
    .quotient(quot)
  );

  // interpolation operands; distance and span are never negative here
  always_comb begin
    dist_full = {cur_thr[SW-1], cur_thr} - {cmd_reg.score[SW-1], cmd_reg.score};
    span_full = {cur_thr[SW-1], cur_thr} - {prev_thr[SW-1], prev_thr};
    prob_diff = $signed({1'b0, cur_prob}) - $signed({1'b0, prev_prob});
    prob_mag  = prob_diff[PW] ? PW'(-prob_diff) : prob_diff[PW-1:0];
  end

  always_comb begin
    if (neg) begin
      interp = $signed({2'b00, cur_prob}) + $signed({2'b00, quot});
    end else begin
      interp = $signed({2'b00, cur_prob}) - $signed({2'b00, quot});
    end
    if (interp < $signed({2'b00, scint_pkg::PROB_TINY})) begin
      interp_clamped = scint_pkg::PROB_TINY;
    end else if (interp > $signed({2'b00, scint_pkg::PROB_MASK})) begin
      interp_clamped = scint_pkg::PROB_MASK;
    end else begin
      interp_clamped = interp[PW-1:0];
    end
    last_floored = (rd.prob < scint_pkg::PROB_TINY) ? scint_pkg::PROB_TINY : rd.prob;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= '0;
    end else if (cfg_we) begin
      entries_in_use <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      done   <= 1'b0;
      scan_i <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cmd_reg <= cmd;
            state   <= S_DECODE;
          end
        end
        S_DECODE: begin
          result.probability <= '0;
          result.bucket      <= cmd_reg.entry_index;
          result.status      <= scint_pkg::ST_OK;
          scan_i             <= '0;
          unique case (cmd_reg.operation)
            scint_pkg::OP_WRITE: begin
              done  <= 1'b1;
              state <= S_IDLE;
            end
            scint_pkg::OP_QUERY_SCORE: begin
              if (n_active == '0) begin
                result.bucket <= '0;
                result.status <= scint_pkg::ST_EMPTY;
                done          <= 1'b1;
                state         <= S_IDLE;
              end else begin
                state <= S_SCAN_RD;
              end
            end
            scint_pkg::OP_QUERY_INDEX: begin
              if (n_active == '0) begin
                result.status <= scint_pkg::ST_EMPTY;
                done          <= 1'b1;
                state         <= S_IDLE;
              end else if ({1'b0, cmd_reg.entry_index} >= n_active) begin
                result.status <= scint_pkg::ST_RANGE;
                done          <= 1'b1;
                state         <= S_IDLE;
              end else begin
                state <= S_IDXRD;
              end
            end
            default: begin
              result.bucket <= '0;
              done          <= 1'b1;
              state         <= S_IDLE;
            end
          endcase
        end
        S_IDXRD: begin
          result.probability <= rd.prob;
          done               <= 1'b1;
          state              <= S_IDLE;
        end
        S_SCAN_RD: begin
          state <= S_SCAN_CMP;
        end
        S_SCAN_CMP: begin
          result.bucket <= scan_i[IDX_W_SEL-1:0];
          if ($signed(rd.thr) >= $signed(cmd_reg.score)) begin
            if (scan_i == '0 || scan_i == n_active - NW'(1)) begin
              result.probability <= rd.prob;
              done               <= 1'b1;
              state              <= S_IDLE;
            end else begin
              cur_thr  <= rd.thr;
              cur_prob <= rd.prob;
              state    <= S_MUL;
            end
          end else if (scan_i == n_active - NW'(1)) begin
            // score above every threshold: take the last entry
            result.probability <= last_floored;
            done               <= 1'b1;
            state              <= S_IDLE;
          end else begin
            prev_thr  <= rd.thr;
            prev_prob <= rd.prob;
            scan_i    <= scan_i + NW'(1);
            state     <= S_SCAN_RD;
          end
        end
        S_MUL: begin
          product <= dist_full[SW-1:0] * prob_mag;
          span    <= span_full[SW-1:0];
          neg     <= prob_diff[PW];
          state   <= S_DIV_GO;
        end
        S_DIV_GO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            result.probability <= interp_clamped;
            done               <= 1'b1;
            state              <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = (state != S_IDLE);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted beat did not make the block busy");

  a_done_from_work: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result strobe without work in progress");

  a_div_in_wait: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV)
    else $error("divider finished outside its wait state");

  a_write_in_decode: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> state == S_DECODE && cmd_reg.operation == scint_pkg::OP_WRITE)
    else $error("table written outside a write beat");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN_CMP) |-> scan_i < n_active)
    else $error("scan index beyond the active entries");

endmodule

`default_nettype wire
